// ===== hdl/two_wire_frame_slave_macros.svh =====
// Assertion macros, clocked on i_clk, disabled while i_rst_n is low
`ifndef TWO_WIRE_FRAME_SLAVE_MACROS_SVH
`define TWO_WIRE_FRAME_SLAVE_MACROS_SVH

`ifndef SYNTH
`define TWFS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("twfs assertion failed");
`define TWFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("twfs implication failed");
`else
`define TWFS_ASSERT(lbl, cond)
`define TWFS_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// ===== hdl/twfs_pkg.sv =====
`timescale 1ns / 1ps
package twfs_pkg;

    localparam int RX_BYTES = 16;
    localparam int TX_BYTES = 6;
    localparam int RX_BITS  = RX_BYTES * 8;
    localparam int TX_BITS  = TX_BYTES * 8;
    localparam int MAX_BITS = (RX_BITS > TX_BITS) ? RX_BITS : TX_BITS;
    localparam int CNT_W    = $clog2(MAX_BITS + 1);
    localparam int BIDX_W   = CNT_W - 3;
    localparam int TX_AW    = (TX_BYTES > 1) ? $clog2(TX_BYTES) : 1;
    localparam int LEN_W    = 5;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;

    localparam logic [LEN_W-1:0] RX_LENGTH_RST = 5'd16;
    localparam logic [LEN_W-1:0] TX_LENGTH_RST = 5'd6;

    localparam logic CFG_RX_LENGTH = 1'b0;
    localparam logic CFG_TX_LENGTH = 1'b1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef enum logic [1:0] {
        PH_WAIT_HIGH,
        PH_WAIT_LOW,
        PH_RECV,
        PH_SEND
    } t_phase;

    typedef struct packed {
        logic       dat_drive_low;
        logic       rx_valid;
        logic [3:0] rx_index;
        logic [7:0] rx_byte;
        logic       frame_done;
    } t_result;

endpackage

// ===== hdl/twfs_ram.sv =====
`timescale 1ns / 1ps
module twfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 6
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/two_wire_frame_slave.sv =====
// Slave side of a master-clocked two-wire frame.
// Input stream: one transaction per pin sample (tuser = 0) or transmit store
// load (tuser = 1, honored only while waiting for a frame start). A frame
// starts when the clock is seen high, then low; 16 bytes are shifted in MSB
// first, then 6 bytes are sent MSB first on the open-drain data line.
// Output stream: exactly one transaction per input transaction, in order.
// tdata carries the line drive and any received byte, tuser flags a
// received byte, tlast flags the end of a frame.
// Results are registered in the output stage. Throughput: one transaction
// per cycle while s_tready is high. Pin state sits in registers; the
// transmit store is a one-port-read RAM whose read address runs ahead from
// the bit counter, so the byte for the next send bit is ready by the edge.
// Stall: a two-entry output stage (register plus skid) absorbs one beat;
// s_tready drops only once the skid entry holds a result.
// Reset (synchronous, active low): waits for clock high, line released,
// lengths 16 and 6, transmit store reads as zero until written.
// Configuration: i_cfg_we writes register i_cfg_addr (0 rx_length,
// 1 tx_length) at the clock edge; write only while no transaction is open.
`timescale 1ns / 1ps
`include "two_wire_frame_slave_macros.svh"
module two_wire_frame_slave (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [0] clk_level, [1] dat_level, [4:2] tx_index, [12:5] tx_byte
    input  logic [twfs_pkg::IN_W-1:0]        i_s_tdata,
    // [0] cmd
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [0] dat_drive_low, [4:1] rx_index, [12:5] rx_byte
    output logic [twfs_pkg::OUT_W-1:0]       o_m_tdata,
    // [0] rx_valid
    output logic                             o_m_tuser,
    // frame_done
    output logic                             o_m_tlast,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_addr,
    input  logic [twfs_pkg::LEN_W-1:0]       i_cfg_wdata
);

    import twfs_pkg::*;

    t_phase              r_phase, n_phase;
    logic                r_seen_high, n_seen_high;
    logic [CNT_W-1:0]    r_bit_count, n_bit_count;
    logic [7:0]          r_shift, n_shift;
    logic                r_drive, n_drive;
    logic [LEN_W-1:0]    r_rx_length;
    logic [LEN_W-1:0]    r_tx_length;
    logic [TX_BYTES-1:0] r_tx_vld;
    logic                r_rd_ok;

    t_result             r_out, r_skid, w_res;
    logic                r_out_valid, r_skid_valid;

    logic                w_accept, w_sample, w_load, w_idle;
    logic                w_clk, w_dat;
    logic [2:0]          w_slot;
    logic [7:0]          w_byte;
    logic [CNT_W-1:0]    w_nb;
    logic [BIDX_W-1:0]   w_nb_idx, w_rx_idx, w_bidx;
    logic [2:0]          w_bpos;
    logic                w_bidx_ok;
    logic [TX_AW-1:0]    w_raddr;
    logic [7:0]          w_rdata, w_tx_b;
    logic                w_bit;

    assign o_s_tready = !r_skid_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_clk      = i_s_tdata[0];
    assign w_dat      = i_s_tdata[1];
    assign w_slot     = i_s_tdata[4:2];
    assign w_byte     = i_s_tdata[12:5];
    assign w_idle     = (r_phase == PH_WAIT_HIGH) || (r_phase == PH_WAIT_LOW);
    assign w_sample   = w_accept && (i_s_tuser == CMD_SAMPLE);
    assign w_load     = w_accept && (i_s_tuser == CMD_LOAD) && w_idle
                        && (int'(w_slot) < TX_BYTES);

    assign w_nb      = r_bit_count + 1'b1;
    assign w_nb_idx  = w_nb[CNT_W-1:3];
    assign w_rx_idx  = w_nb_idx - 1'b1;
    assign w_bidx    = (r_phase == PH_SEND) ? w_nb_idx : '0;
    assign w_bpos    = (r_phase == PH_SEND) ? w_nb[2:0] : 3'd0;
    assign w_bidx_ok = int'(w_bidx) < TX_BYTES;
    assign w_raddr   = w_bidx_ok ? TX_AW'(w_bidx) : '0;

    twfs_ram #(
        .WIDTH(8),
        .DEPTH(TX_BYTES)
    ) u_tx_store (
        .i_clk  (i_clk),
        .i_we   (w_load),
        .i_waddr(TX_AW'(w_slot)),
        .i_wdata(w_byte),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_tx_b = (r_rd_ok && (int'(w_bidx) < int'(r_tx_length))) ? w_rdata : 8'h00;
    assign w_bit  = w_tx_b[3'd7 - w_bpos];

    always_comb begin
        n_phase = r_phase;
        if (w_sample) begin
            case (r_phase)
                PH_WAIT_HIGH: begin
                    if (w_clk) n_phase = PH_WAIT_LOW;
                end
                PH_WAIT_LOW: begin
                    if (!w_clk) n_phase = PH_RECV;
                end
                PH_RECV: begin
                    if (r_seen_high && !w_clk && (w_nb >= CNT_W'(RX_BITS))) n_phase = PH_SEND;
                end
                PH_SEND: begin
                    if (r_seen_high && !w_clk && (w_nb >= CNT_W'(TX_BITS))) begin
                        n_phase = PH_WAIT_HIGH;
                    end
                end
                default: n_phase = PH_WAIT_HIGH;
            endcase
        end
    end

    always_comb begin
        n_seen_high = r_seen_high;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_drive     = r_drive;
        w_res       = '0;
        if (w_sample) begin
            case (r_phase)
                PH_WAIT_HIGH: begin
                end
                PH_WAIT_LOW: begin
                    if (!w_clk) begin
                        n_seen_high = 1'b0;
                        n_bit_count = '0;
                        n_shift     = 8'h00;
                        n_drive     = 1'b0;
                    end
                end
                PH_RECV: begin
                    if (!r_seen_high) begin
                        if (w_clk) begin
                            n_shift     = {r_shift[6:0], w_dat};
                            n_seen_high = 1'b1;
                        end
                    end else if (!w_clk) begin
                        n_seen_high = 1'b0;
                        n_bit_count = w_nb;
                        if (w_nb[2:0] == 3'd0) begin
                            if (int'(w_rx_idx) < int'(r_rx_length)) begin
                                w_res.rx_valid = 1'b1;
                                w_res.rx_index = 4'(w_rx_idx);
                                w_res.rx_byte  = r_shift;
                            end
                            n_shift = 8'h00;
                        end
                        if (w_nb >= CNT_W'(RX_BITS)) begin
                            n_bit_count = '0;
                            n_drive     = !w_bit;
                        end
                    end
                end
                PH_SEND: begin
                    if (!r_seen_high) begin
                        if (w_clk) n_seen_high = 1'b1;
                    end else if (!w_clk) begin
                        n_seen_high = 1'b0;
                        if (w_nb >= CNT_W'(TX_BITS)) begin
                            n_drive          = 1'b0;
                            n_bit_count      = '0;
                            w_res.frame_done = 1'b1;
                        end else begin
                            n_bit_count = w_nb;
                            n_drive     = !w_bit;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        w_res.dat_drive_low = n_drive;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT_HIGH;
            r_seen_high  <= 1'b0;
            r_bit_count  <= '0;
            r_drive      <= 1'b0;
            r_rx_length  <= RX_LENGTH_RST;
            r_tx_length  <= TX_LENGTH_RST;
            r_tx_vld     <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_seen_high <= n_seen_high;
            r_bit_count <= n_bit_count;
            r_drive     <= n_drive;
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_RX_LENGTH) r_rx_length <= i_cfg_wdata;
                if (i_cfg_addr == CFG_TX_LENGTH) r_tx_length <= i_cfg_wdata;
            end
            if (w_load) r_tx_vld[TX_AW'(w_slot)] <= 1'b1;
            if (r_out_valid && i_m_tready) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_accept;
                end
            end else if (w_accept) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_rd_ok <= w_bidx_ok && r_tx_vld[w_raddr];
        if (r_out_valid && i_m_tready) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_accept) begin
            if (r_out_valid) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.rx_byte, r_out.rx_index, r_out.dat_drive_low};
    assign o_m_tuser  = r_out.rx_valid;
    assign o_m_tlast  = r_out.frame_done;

    `TWFS_ASSERT_IMP(a_skid_behind_out, r_skid_valid, r_out_valid)
    `TWFS_ASSERT_IMP(a_no_load_in_frame, !w_idle, !w_load)
    `TWFS_ASSERT_IMP(a_done_releases, o_m_tvalid && o_m_tlast, !o_m_tdata[0] && !o_m_tuser)
    `TWFS_ASSERT_IMP(a_drive_only_send, r_drive, r_phase == PH_SEND)

endmodule
